@@ src/tgs_pkg.sv @@
// shared constants, types and helper functions of the triangle geometry stage
// no dependencies
`timescale 1ns / 1ps

package tgs_pkg;

  localparam int CFG_AW = 6;
  localparam int CFG_DW = 64;

  localparam logic [2:0] REG_VIEW_ROW0 = 3'd0;
  localparam logic [2:0] REG_VIEW_ROW1 = 3'd1;
  localparam logic [2:0] REG_VIEW_ROW2 = 3'd2;
  localparam logic [2:0] REG_VIEW_ROW3 = 3'd3;
  localparam logic [2:0] REG_PROJ_ROW0 = 3'd4;
  localparam logic [2:0] REG_PROJ_ROW1 = 3'd5;
  localparam logic [2:0] REG_PROJ_ROW2 = 3'd6;
  localparam logic [2:0] REG_PROJ_ROW3 = 3'd7;

  localparam logic [63:0] IDENT_ROW0 = 64'h0000_0000_0000_1000;
  localparam logic [63:0] IDENT_ROW1 = 64'h0000_0000_1000_0000;
  localparam logic [63:0] IDENT_ROW2 = 64'h0000_1000_0000_0000;
  localparam logic [63:0] IDENT_ROW3 = 64'h1000_0000_0000_0000;

  localparam logic signed [31:0] ONE_Q16   = 32'sd65536;
  localparam int                 LIGHT_Q16 = 46334;
  localparam int                 TANX_NUM  = 5;
  localparam int                 TANX_DEN  = 4;
  localparam int                 LEVEL_MAX = 255;
  localparam int                 NORM_BITS = 15;

  // S1..S36, the output register comes after
  localparam int PIPE_DEPTH = 36;
  localparam int VP_DIV_QW  = 15;
  localparam int LVL_DIV_QW = 8;

  typedef struct packed {
    logic [15:0]        idx;
    logic               vis;
    logic signed [33:0] dsum;
  } side_t;

  function automatic logic signed [15:0] lane(input logic [63:0] row, input int k);
    return row[16*k +: 16];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (x < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return 32'(x);
  endfunction

  function automatic logic signed [33:0] mag34(input logic signed [31:0] x);
    return (x < 0) ? -34'(x) : 34'(x);
  endfunction

endpackage

@@ src/tgs_channels.sv @@
// request channels of the triangle geometry stage: triangle in, result out
// no dependencies
`timescale 1ns / 1ps

interface tgs_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        tri_index;
  logic signed [31:0] v0_x;
  logic signed [31:0] v0_y;
  logic signed [31:0] v0_z;
  logic signed [31:0] v1_x;
  logic signed [31:0] v1_y;
  logic signed [31:0] v1_z;
  logic signed [31:0] v2_x;
  logic signed [31:0] v2_y;
  logic signed [31:0] v2_z;

  modport source(output valid, tri_index, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                 v2_x, v2_y, v2_z, input ready);
  modport sink(input valid, tri_index, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
               v2_x, v2_y, v2_z, output ready);
endinterface

interface tgs_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        out_index;
  logic               visible;
  logic signed [15:0] screen_x0;
  logic signed [15:0] screen_y0;
  logic signed [15:0] screen_x1;
  logic signed [15:0] screen_y1;
  logic signed [15:0] screen_x2;
  logic signed [15:0] screen_y2;
  logic [7:0]         intensity;
  logic signed [33:0] depth_key;

  modport source(output valid, out_index, visible, screen_x0, screen_y0, screen_x1,
                 screen_y1, screen_x2, screen_y2, intensity, depth_key, input ready);
  modport sink(input valid, out_index, visible, screen_x0, screen_y0, screen_x1,
               screen_y1, screen_x2, screen_y2, intensity, depth_key, output ready);
endinterface

@@ src/tgs_div.sv @@
// pipelined restoring divider, one quotient bit per stage, overflow flag
// no dependencies
`timescale 1ns / 1ps

module tgs_div #(
  parameter int NW = 48,
  parameter int DW = 33,
  parameter int QW = 15
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          ovf
);

  localparam int XW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [XW-1:0] rem [QW+1];
  logic [DW-1:0] dd  [QW+1];
  logic [QW-1:0] q   [QW+1];
  logic          ov  [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= XW'(num);
      dd[0]  <= den;
      q[0]   <= '0;
      ov[0]  <= XW'(num) >= (XW'(den) << QW);
      for (int t = 1; t <= QW; t++) begin
        dd[t] <= dd[t-1];
        ov[t] <= ov[t-1];
        if (rem[t-1] >= (XW'(dd[t-1]) << (QW - t))) begin
          rem[t] <= rem[t-1] - (XW'(dd[t-1]) << (QW - t));
          q[t]   <= q[t-1] | (QW'(1) << (QW - t));
        end else begin
          rem[t] <= rem[t-1];
          q[t]   <= q[t-1];
        end
      end
    end
  end

  assign quo = q[QW];
  assign ovf = ov[QW];

endmodule

@@ src/tgs_sqrt.sv @@
// pipelined integer square root, one result bit per stage, floor result
// no dependencies
`timescale 1ns / 1ps

module tgs_sqrt #(
  parameter int RW = 16
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] rad,
  output logic [RW-1:0]   root
);

  localparam int SW = 2 * RW;

  logic [SW-1:0] n   [RW];
  logic [SW:0]   res [RW];

  function automatic logic [SW:0] step_bit(input int k);
    return (SW + 1)'(1) << (2 * (RW - 1 - k));
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      if ((SW + 1)'(rad) >= step_bit(0)) begin
        n[0]   <= SW'((SW + 1)'(rad) - step_bit(0));
        res[0] <= step_bit(0);
      end else begin
        n[0]   <= rad;
        res[0] <= '0;
      end
      for (int k = 1; k < RW; k++) begin
        if ((SW + 1)'(n[k-1]) >= res[k-1] + step_bit(k)) begin
          n[k]   <= SW'((SW + 1)'(n[k-1]) - (res[k-1] + step_bit(k)));
          res[k] <= (res[k-1] >> 1) + step_bit(k);
        end else begin
          n[k]   <= n[k-1];
          res[k] <= res[k-1] >> 1;
        end
      end
    end
  end

  assign root = res[RW-1][RW-1:0];

endmodule

@@ src/triangle_geometry_stage.sv @@
// triangle geometry stage: transform, cull, project, viewport map, flat shade
// depends on tgs_pkg, tgs_channels, tgs_div, tgs_sqrt
// throughput: one triangle per cycle, the whole pipeline holds while the output stalls
// reset clears the pipeline valid bits and loads identity view and projection matrices
`timescale 1ns / 1ps

module triangle_geometry_stage
  import tgs_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic              clk,
  input  logic              rst,
  tgs_in_if.sink            in_ch,
  tgs_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int VP_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int VP_MW  = $clog2(VP_MAX + 1);
  localparam int NUM_W  = 33 + VP_MW + 1;
  localparam int UN_W   = NUM_W + 1;
  localparam logic signed [VP_MW:0] SW_S = (VP_MW + 1)'(SCREEN_WIDTH);
  localparam logic signed [VP_MW:0] SH_S = (VP_MW + 1)'(SCREEN_HEIGHT);

  // configuration
  logic [63:0] view [4];
  logic [63:0] proj [4];
  logic [2:0]  reg_sel;

  assign reg_sel = paddr[5:3];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      view[0] <= IDENT_ROW0;
      view[1] <= IDENT_ROW1;
      view[2] <= IDENT_ROW2;
      view[3] <= IDENT_ROW3;
      proj[0] <= IDENT_ROW0;
      proj[1] <= IDENT_ROW1;
      proj[2] <= IDENT_ROW2;
      proj[3] <= IDENT_ROW3;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_VIEW_ROW0: view[0] <= pwdata;
        REG_VIEW_ROW1: view[1] <= pwdata;
        REG_VIEW_ROW2: view[2] <= pwdata;
        REG_VIEW_ROW3: view[3] <= pwdata;
        REG_PROJ_ROW0: proj[0] <= pwdata;
        REG_PROJ_ROW1: proj[1] <= pwdata;
        REG_PROJ_ROW2: proj[2] <= pwdata;
        REG_PROJ_ROW3: proj[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_VIEW_ROW0: prdata = view[0];
      REG_VIEW_ROW1: prdata = view[1];
      REG_VIEW_ROW2: prdata = view[2];
      REG_VIEW_ROW3: prdata = view[3];
      REG_PROJ_ROW0: prdata = proj[0];
      REG_PROJ_ROW1: prdata = proj[1];
      REG_PROJ_ROW2: prdata = proj[2];
      REG_PROJ_ROW3: prdata = proj[3];
      default:       prdata = '0;
    endcase
  end

  // view-space light, follows the view matrix
  logic signed [31:0] lv [3];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      lv[j] <= sat32(((64'(lane(view[j], 0)) - 64'(lane(view[j], 1)))
                      * 64'(LIGHT_Q16)) >>> 12);
    end
  end

  // pipeline control
  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld;
  logic                  ovalid;

  assign adv         = !ovalid || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      ovalid <= 1'b0;
    end else if (adv) begin
      vld    <= {vld[PIPE_DEPTH-2:0], in_ch.valid};
      ovalid <= vld[PIPE_DEPTH-1];
    end
  end

  // S1 view products
  logic signed [31:0] vin [3][3];
  logic signed [47:0] s1_p [3][4][3];
  logic [15:0]        s1_idx;

  assign vin[0][0] = in_ch.v0_x;
  assign vin[0][1] = in_ch.v0_y;
  assign vin[0][2] = in_ch.v0_z;
  assign vin[1][0] = in_ch.v1_x;
  assign vin[1][1] = in_ch.v1_y;
  assign vin[1][2] = in_ch.v1_z;
  assign vin[2][0] = in_ch.v2_x;
  assign vin[2][1] = in_ch.v2_y;
  assign vin[2][2] = in_ch.v2_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx <= in_ch.tri_index;
      for (int i = 0; i < 3; i++)
        for (int r = 0; r < 4; r++)
          for (int k = 0; k < 3; k++)
            s1_p[i][r][k] <= lane(view[r], k) * vin[i][k];
    end
  end

  // S2 view sums
  logic signed [49:0] acc2 [3][4];
  logic signed [31:0] s2_vt [3][4];
  logic [15:0]        s2_idx;

  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int r = 0; r < 4; r++)
        acc2[i][r] = 50'(s1_p[i][r][0]) + 50'(s1_p[i][r][1]) + 50'(s1_p[i][r][2])
                   + (50'(lane(view[r], 3)) <<< 16);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_idx <= s1_idx;
      for (int i = 0; i < 3; i++)
        for (int r = 0; r < 4; r++)
          s2_vt[i][r] <= sat32(64'(acc2[i][r] >>> 12));
    end
  end

  // S3 projection products, edges, field of view tests, depth sum
  logic signed [47:0] s3_pp [3][3][4];
  logic signed [32:0] s3_l1 [3];
  logic signed [32:0] s3_l2 [3];
  logic signed [31:0] s3_v0 [3];
  logic signed [33:0] s3_dsum;
  logic               s3_zok, s3_allx, s3_ally;
  logic [15:0]        s3_idx;
  logic               zok_next, allx_next, ally_next;

  always_comb begin
    zok_next  = 1'b1;
    allx_next = 1'b1;
    ally_next = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (!(s2_vt[i][2] > ONE_Q16)) zok_next = 1'b0;
      if (!((36'(s2_vt[i][2]) * 36'(TANX_NUM))
            < (36'(mag34(s2_vt[i][0])) * 36'(TANX_DEN)))) allx_next = 1'b0;
      if (!(34'(s2_vt[i][2]) < mag34(s2_vt[i][1]))) ally_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_idx  <= s2_idx;
      s3_zok  <= zok_next;
      s3_allx <= allx_next;
      s3_ally <= ally_next;
      s3_dsum <= 34'(s2_vt[0][2]) + 34'(s2_vt[1][2]) + 34'(s2_vt[2][2]);
      for (int j = 0; j < 3; j++) begin
        s3_l1[j] <= 33'(s2_vt[1][j]) - 33'(s2_vt[0][j]);
        s3_l2[j] <= 33'(s2_vt[2][j]) - 33'(s2_vt[0][j]);
        s3_v0[j] <= s2_vt[0][j];
      end
      // projected rows x, y and w
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          for (int k = 0; k < 4; k++)
            s3_pp[i][j][k] <= lane(proj[(j == 2) ? 3 : j], k) * s2_vt[i][k];
    end
  end

  // S4 projection sums, cross product terms
  logic signed [49:0] acc4 [3][3];
  logic signed [31:0] s4_pt [3][3];
  logic signed [65:0] s4_pa [3];
  logic signed [65:0] s4_pb [3];
  logic signed [31:0] s4_v0 [3];
  logic signed [33:0] s4_dsum;
  logic               s4_zok, s4_allx, s4_ally;
  logic [15:0]        s4_idx;

  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        acc4[i][j] = 50'(s3_pp[i][j][0]) + 50'(s3_pp[i][j][1])
                   + 50'(s3_pp[i][j][2]) + 50'(s3_pp[i][j][3]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_idx  <= s3_idx;
      s4_zok  <= s3_zok;
      s4_allx <= s3_allx;
      s4_ally <= s3_ally;
      s4_dsum <= s3_dsum;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          s4_pt[i][j] <= sat32(64'(acc4[i][j] >>> 12));
      for (int j = 0; j < 3; j++) begin
        s4_v0[j] <= s3_v0[j];
        s4_pa[j] <= s3_l1[(j + 1) % 3] * s3_l2[(j + 2) % 3];
        s4_pb[j] <= s3_l1[(j + 2) % 3] * s3_l2[(j + 1) % 3];
      end
    end
  end

  // S5 normal, viewport numerators and denominators
  logic signed [31:0]      dv5 [3];
  logic signed [66:0]      s5_n [3];
  logic signed [NUM_W-1:0] s5_num [3][2];
  logic signed [33:0]      s5_den [3];
  logic signed [31:0]      s5_v0 [3];
  logic signed [33:0]      s5_dsum;
  logic                    s5_zok, s5_allx, s5_ally;
  logic [15:0]             s5_idx;

  always_comb begin
    for (int i = 0; i < 3; i++)
      dv5[i] = (s4_pt[i][2] != 0) ? s4_pt[i][2] : ONE_Q16;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_idx  <= s4_idx;
      s5_zok  <= s4_zok;
      s5_allx <= s4_allx;
      s5_ally <= s4_ally;
      s5_dsum <= s4_dsum;
      for (int j = 0; j < 3; j++) begin
        s5_v0[j] <= s4_v0[j];
        s5_n[j]  <= 67'(s4_pa[j]) - 67'(s4_pb[j]);
      end
      for (int i = 0; i < 3; i++) begin
        s5_num[i][0] <= NUM_W'(33'(s4_pt[i][0]) + 33'(dv5[i])) * NUM_W'(SW_S);
        s5_num[i][1] <= NUM_W'(33'(s4_pt[i][1]) + 33'(dv5[i])) * NUM_W'(SH_S);
        s5_den[i]    <= 34'(dv5[i]) <<< 1;
      end
    end
  end

  // S6 divider operands, dot product partials, normal magnitude
  logic [UN_W-1:0]    un_next [6];
  logic [32:0]        ud_next [6];
  logic               neg_next [6];
  logic [66:0]        nor_next;
  logic [UN_W-1:0]    s6_un [6];
  logic [32:0]        s6_ud [6];
  logic               s6_neg [6];
  logic signed [66:0] s6_pl [3];
  logic signed [64:0] s6_ph [3];
  logic [66:0]        s6_nor;
  logic signed [66:0] s6_n [3];
  logic signed [33:0] s6_dsum;
  logic               s6_zok, s6_allx, s6_ally;
  logic [15:0]        s6_idx;

  always_comb begin
    logic signed [UN_W-1:0] nn;
    logic signed [33:0]     dd;
    for (int k = 0; k < 6; k++) begin
      nn = UN_W'(s5_num[k/2][k%2]);
      dd = s5_den[k/2];
      if (dd < 0) begin
        nn = -nn;
        dd = -dd;
      end
      ud_next[k] = 33'(dd);
      if (nn < 0) begin
        neg_next[k] = 1'b1;
        un_next[k]  = UN_W'(-nn) + UN_W'(dd) - UN_W'(1);
      end else begin
        neg_next[k] = 1'b0;
        un_next[k]  = UN_W'(nn);
      end
    end
    nor_next = '0;
    for (int j = 0; j < 3; j++)
      nor_next = nor_next | (s5_n[j][66] ? 67'(-s5_n[j]) : 67'(s5_n[j]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_idx  <= s5_idx;
      s6_zok  <= s5_zok;
      s6_allx <= s5_allx;
      s6_ally <= s5_ally;
      s6_dsum <= s5_dsum;
      s6_nor  <= nor_next;
      for (int k = 0; k < 6; k++) begin
        s6_un[k]  <= un_next[k];
        s6_ud[k]  <= ud_next[k];
        s6_neg[k] <= neg_next[k];
      end
      for (int j = 0; j < 3; j++) begin
        s6_n[j]  <= s5_n[j];
        s6_pl[j] <= $signed({1'b0, s5_n[j][33:0]}) * s5_v0[j];
        s6_ph[j] <= $signed(s5_n[j][66:34]) * s5_v0[j];
      end
    end
  end

  // S7 back face sign, visibility, normalizing shift
  logic signed [66:0]  dot_h;
  logic signed [68:0]  dot_l;
  logic signed [104:0] dot7;
  logic [6:0]          bl7;
  side_t               side_next;
  side_t               s7_side;
  logic [6:0]          s7_s;
  logic signed [66:0]  s7_n [3];

  always_comb begin
    dot_h = 67'(s6_ph[0]) + 67'(s6_ph[1]) + 67'(s6_ph[2]);
    dot_l = 69'(s6_pl[0]) + 69'(s6_pl[1]) + 69'(s6_pl[2]);
    dot7  = (105'(dot_h) <<< 34) + 105'(dot_l);
    bl7   = '0;
    for (int b = 0; b < 67; b++)
      if (s6_nor[b]) bl7 = 7'(b + 1);
    side_next.idx  = s6_idx;
    side_next.vis  = dot7[104] && s6_zok && !s6_allx && !s6_ally;
    side_next.dsum = s6_dsum;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_side <= side_next;
      s7_s    <= (bl7 > 7'(NORM_BITS)) ? bl7 - 7'(NORM_BITS) : 7'd0;
      for (int j = 0; j < 3; j++) s7_n[j] <= s6_n[j];
    end
  end

  // S8 scaled normal
  logic signed [16:0] s8_ns [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) s8_ns[j] <= 17'(s7_n[j] >>> s7_s);
    end
  end

  // S9 squares and light products
  logic signed [33:0] s9_sq [3];
  logic signed [48:0] s9_e [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        s9_sq[j] <= s8_ns[j] * s8_ns[j];
        s9_e[j]  <= s8_ns[j] * lv[j];
      end
    end
  end

  // S10 sums
  logic [31:0]        s10_sq;
  logic signed [50:0] s10_e;

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_sq <= 32'(35'(s9_sq[0]) + 35'(s9_sq[1]) + 35'(s9_sq[2]));
      s10_e  <= 51'(s9_e[0]) + 51'(s9_e[1]) + 51'(s9_e[2]);
    end
  end

  // S11..S26 normal length
  logic [15:0]        nlen;
  logic signed [50:0] e_dly [16];

  tgs_sqrt #(.RW(16)) u_sqrt (
    .clk  (clk),
    .en   (adv),
    .rad  (s10_sq),
    .root (nlen)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      e_dly[0] <= s10_e;
      for (int k = 1; k < 16; k++) e_dly[k] <= e_dly[k-1];
    end
  end

  // S27 intensity operands
  logic [15:0]        rr27;
  logic signed [51:0] t27;
  logic signed [59:0] num27;
  logic [58:0]        s27_un;
  logic [32:0]        s27_ud;
  logic               s27_neg;

  always_comb begin
    rr27  = (nlen == 16'd0) ? 16'd1 : nlen;
    t27   = 52'(e_dly[15]) + (52'($signed({1'b0, rr27})) <<< 16);
    num27 = 60'(t27) * 60'(LEVEL_MAX);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s27_neg <= num27 < 0;
      s27_un  <= (num27 < 0) ? 59'd0 : 59'(num27);
      s27_ud  <= {rr27, 17'd0};
    end
  end

  // S28..S36 intensity division
  logic [LVL_DIV_QW-1:0] lvl_q;
  logic                  lvl_ovf;
  logic                  lneg_dly [LVL_DIV_QW+1];

  tgs_div #(.NW(59), .DW(33), .QW(LVL_DIV_QW)) u_lvl_div (
    .clk (clk),
    .en  (adv),
    .num (s27_un),
    .den (s27_ud),
    .quo (lvl_q),
    .ovf (lvl_ovf)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      lneg_dly[0] <= s27_neg;
      for (int k = 1; k <= LVL_DIV_QW; k++) lneg_dly[k] <= lneg_dly[k-1];
    end
  end

  // S7..S22 viewport divisions
  logic [VP_DIV_QW-1:0] vp_q [6];
  logic                 vp_ovf [6];
  logic                 vneg_dly [VP_DIV_QW+1];
  logic [5:0]           vneg_vec;

  for (genvar k = 0; k < 6; k++) begin : g_vp
    tgs_div #(.NW(UN_W), .DW(33), .QW(VP_DIV_QW)) u_vp_div (
      .clk (clk),
      .en  (adv),
      .num (s6_un[k]),
      .den (s6_ud[k]),
      .quo (vp_q[k]),
      .ovf (vp_ovf[k])
    );
    assign vneg_vec[k] = s6_neg[k];
  end

  logic [5:0] vneg_q [VP_DIV_QW+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      vneg_q[0] <= vneg_vec;
      for (int k = 1; k <= VP_DIV_QW; k++) vneg_q[k] <= vneg_q[k-1];
    end
  end

  // S23 saturated pixel coordinates, then carried to S36
  logic [5:0][15:0] vp_next;
  logic [5:0][15:0] vp_dly [14];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      if (vp_ovf[k]) begin
        vp_next[k] = vneg_q[VP_DIV_QW][k] ? 16'h8000 : 16'h7FFF;
      end else if (vneg_q[VP_DIV_QW][k]) begin
        vp_next[k] = 16'(-$signed({1'b0, vp_q[k]}));
      end else begin
        vp_next[k] = {1'b0, vp_q[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vp_dly[0] <= vp_next;
      for (int k = 1; k < 14; k++) vp_dly[k] <= vp_dly[k-1];
    end
  end

  // S8..S36 index, visibility and depth
  side_t side_dly [29];

  always_ff @(posedge clk) begin
    if (adv) begin
      side_dly[0] <= s7_side;
      for (int k = 1; k < 29; k++) side_dly[k] <= side_dly[k-1];
    end
  end

  // output register
  side_t fin;
  logic  fin_neg;

  assign fin     = side_dly[28];
  assign fin_neg = lneg_dly[LVL_DIV_QW];
  assign out_ch.valid = ovalid;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.out_index <= fin.idx;
      out_ch.visible   <= fin.vis;
      if (fin.vis) begin
        out_ch.screen_x0 <= vp_dly[13][0];
        out_ch.screen_y0 <= vp_dly[13][1];
        out_ch.screen_x1 <= vp_dly[13][2];
        out_ch.screen_y1 <= vp_dly[13][3];
        out_ch.screen_x2 <= vp_dly[13][4];
        out_ch.screen_y2 <= vp_dly[13][5];
        out_ch.depth_key <= fin.dsum;
        if (fin_neg) begin
          out_ch.intensity <= 8'd0;
        end else if (lvl_ovf) begin
          out_ch.intensity <= 8'(LEVEL_MAX);
        end else begin
          out_ch.intensity <= lvl_q;
        end
      end else begin
        out_ch.screen_x0 <= '0;
        out_ch.screen_y0 <= '0;
        out_ch.screen_x1 <= '0;
        out_ch.screen_y1 <= '0;
        out_ch.screen_x2 <= '0;
        out_ch.screen_y2 <= '0;
        out_ch.depth_key <= '0;
        out_ch.intensity <= '0;
      end
    end
  end

endmodule

@@ bench/triangle_geometry_stage_tb.sv @@
// self-checking bench of triangle_geometry_stage: transform, cull, viewport map, shading
// uses tgs_pkg and tgs_channels; matrices written over the config port between phases
// a bit-exact predictor runs on every accepted triangle, results checked in order
`timescale 1ns / 1ps

module triangle_geometry_stage_tb;
  import tgs_pkg::*;

  typedef struct {
    logic [15:0]        idx;
    logic signed [31:0] c [9];
  } triangle_t;

  typedef struct {
    logic [15:0]        idx;
    logic               vis;
    logic signed [15:0] sx [3];
    logic signed [15:0] sy [3];
    logic [7:0]         level;
    logic signed [33:0] depth;
  } raster_t;

  localparam int WATCHDOG_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  tgs_in_if  in_ch ();
  tgs_out_if out_ch ();

  triangle_geometry_stage u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  logic [63:0] view_m [4];
  logic [63:0] proj_m [4];
  triangle_t triangle_q [$];
  raster_t   raster_q [$];
  triangle_t next_tri;
  logic in_taken = 1'b0;
  logic calm = 1'b0;
  int errors = 0;
  int idle_cycles = 0;

  function automatic logic signed [31:0] row_mul(input logic [63:0] row,
                                                 input logic signed [31:0] v [4]);
    logic signed [63:0] acc;
    logic signed [63:0] x;
    acc = 0;
    for (int k = 0; k < 4; k++) begin
      x = v[k];
      acc = acc + $signed(row[16*k +: 16]) * x;
    end
    acc = acc >>> 12;
    if (acc > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (acc < -64'sd2147483648) return 32'sh8000_0000;
    return acc[31:0];
  endfunction

  function automatic logic signed [63:0] floor_div(input logic signed [63:0] num,
                                                   input logic signed [63:0] den);
    logic signed [63:0] q;
    q = num / den;
    if ((num % den != 0) && ((num < 0) != (den < 0))) q = q - 1;
    return q;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
    if (x > 64'sd32767) return 16'sh7FFF;
    if (x < -64'sd32768) return 16'sh8000;
    return x[15:0];
  endfunction

  function automatic raster_t project_triangle(input triangle_t t);
    raster_t r;
    logic signed [31:0] vin [4];
    logic signed [31:0] vt [3][4];
    logic signed [31:0] pt [3][4];
    logic signed [31:0] lin [4];
    logic signed [31:0] lv [4];
    logic signed [127:0] l1 [3];
    logic signed [127:0] l2 [3];
    logic signed [127:0] n [3];
    logic signed [127:0] dot, mag, sh;
    logic signed [63:0] z, ax, ay, d, e, num, den, q, ns;
    logic [63:0] sq, root;
    int bl, s, a, b;
    logic zok, allx, ally;
    r.idx = t.idx;
    r.vis = 1'b0;
    r.level = '0;
    r.depth = '0;
    for (int i = 0; i < 3; i++) begin
      r.sx[i] = '0;
      r.sy[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) vin[j] = t.c[3*i+j];
      vin[3] = ONE_Q16;
      for (int k = 0; k < 4; k++) vt[i][k] = row_mul(view_m[k], vin);
      for (int k = 0; k < 4; k++) pt[i][k] = row_mul(proj_m[k], vt[i]);
    end
    for (int j = 0; j < 3; j++) begin
      l1[j] = vt[1][j];
      l1[j] = l1[j] - vt[0][j];
      l2[j] = vt[2][j];
      l2[j] = l2[j] - vt[0][j];
    end
    for (int j = 0; j < 3; j++) begin
      a = (j + 1) % 3;
      b = (j + 2) % 3;
      n[j] = l1[a] * l2[b] - l1[b] * l2[a];
    end
    dot = 0;
    for (int j = 0; j < 3; j++) begin
      sh = vt[0][j];
      dot = dot + n[j] * sh;
    end
    zok = 1'b1;
    allx = 1'b1;
    ally = 1'b1;
    for (int i = 0; i < 3; i++) begin
      z = vt[i][2];
      ax = vt[i][0];
      ay = vt[i][1];
      if (ax < 0) ax = -ax;
      if (ay < 0) ay = -ay;
      if (!(z > 65536)) zok = 1'b0;
      if (!(TANX_NUM * z < TANX_DEN * ax)) allx = 1'b0;
      if (!(z < ay)) ally = 1'b0;
    end
    if (!(dot < 0 && zok && !allx && !ally)) return r;
    r.vis = 1'b1;
    for (int i = 0; i < 3; i++) begin
      d = (pt[i][3] != 0) ? 64'(pt[i][3]) : 64'sd65536;
      r.sx[i] = sat16(floor_div((64'(pt[i][0]) + d) * 640, 2 * d));
      r.sy[i] = sat16(floor_div((64'(pt[i][1]) + d) * 480, 2 * d));
    end
    lin[0] = LIGHT_Q16;
    lin[1] = -LIGHT_Q16;
    lin[2] = 0;
    lin[3] = 0;
    for (int k = 0; k < 4; k++) lv[k] = row_mul(view_m[k], lin);
    bl = 0;
    for (int j = 0; j < 3; j++) begin
      mag = (n[j] < 0) ? -n[j] : n[j];
      for (int k = 127; k >= 0; k--) begin
        if (mag[k]) begin
          if (k + 1 > bl) bl = k + 1;
          break;
        end
      end
    end
    s = (bl > NORM_BITS) ? bl - NORM_BITS : 0;
    sq = 0;
    e = 0;
    for (int j = 0; j < 3; j++) begin
      sh = n[j] >>> s;
      ns = sh[63:0];
      sq = sq + 64'(ns * ns);
      e = e + ns * 64'(lv[j]);
    end
    root = 0;
    for (int k = 31; k >= 0; k--) begin
      if ((root | (64'd1 << k)) * (root | (64'd1 << k)) <= sq) root = root | (64'd1 << k);
    end
    if (root == 0) root = 1;
    num = 255 * (e + $signed(root) * 65536);
    den = 2 * $signed(root) * 65536;
    if (num < 0) begin
      r.level = '0;
    end else begin
      q = num / den;
      r.level = (q > 255) ? 8'd255 : q[7:0];
    end
    r.depth = 34'(vt[0][2]) + 34'(vt[1][2]) + 34'(vt[2][2]);
    return r;
  endfunction

  task automatic write_reg(input logic [2:0] regno, input logic [63:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {regno, 3'b000};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (regno < 4) view_m[regno] = value;
    else proj_m[regno - 4] = value;
  endtask

  task automatic load_matrices(input logic [63:0] v0, v1, v2, v3, p0, p1, p2, p3);
    write_reg(REG_VIEW_ROW0, v0);
    write_reg(REG_VIEW_ROW1, v1);
    write_reg(REG_VIEW_ROW2, v2);
    write_reg(REG_VIEW_ROW3, v3);
    write_reg(REG_PROJ_ROW0, p0);
    write_reg(REG_PROJ_ROW1, p1);
    write_reg(REG_PROJ_ROW2, p2);
    write_reg(REG_PROJ_ROW3, p3);
  endtask

  task automatic wait_drained();
    while (triangle_q.size() != 0 || in_ch.valid || raster_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // small signed Q4.12 entry around a given value
  function automatic logic [15:0] near(input int centre, input int spread);
    int v;
    v = centre + $urandom_range(2 * spread) - spread;
    return v[15:0];
  endfunction

  task automatic push_tri(input logic [15:0] idx, input logic signed [31:0] x0, y0, z0,
                          input logic signed [31:0] x1, y1, z1, x2, y2, z2);
    triangle_t t;
    t.idx = idx;
    t.c[0] = x0; t.c[1] = y0; t.c[2] = z0;
    t.c[3] = x1; t.c[4] = y1; t.c[5] = z1;
    t.c[6] = x2; t.c[7] = y2; t.c[8] = z2;
    triangle_q = {triangle_q, t};
  endtask

  task automatic push_random(input int count);
    triangle_t t;
    int z;
    for (int n = 0; n < count; n++) begin
      t.idx = 16'($urandom);
      if ($urandom_range(99) < 25) begin
        for (int j = 0; j < 9; j++) t.c[j] = $urandom;
      end else begin
        for (int i = 0; i < 3; i++) begin
          z = $urandom_range(40 * 65536, 65536 / 2);
          t.c[3*i+2] = z;
          t.c[3*i] = $urandom_range(2 * z) - z;
          t.c[3*i+1] = $urandom_range(2 * z) - z;
        end
      end
      triangle_q = {triangle_q, t};
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_ch.valid || in_taken) begin
        if (triangle_q.size() != 0 && (calm || $urandom_range(99) >= 34)) begin
          next_tri = triangle_q.pop_front();
          in_ch.tri_index <= next_tri.idx;
          in_ch.v0_x <= next_tri.c[0];
          in_ch.v0_y <= next_tri.c[1];
          in_ch.v0_z <= next_tri.c[2];
          in_ch.v1_x <= next_tri.c[3];
          in_ch.v1_y <= next_tri.c[4];
          in_ch.v1_z <= next_tri.c[5];
          in_ch.v2_x <= next_tri.c[6];
          in_ch.v2_y <= next_tri.c[7];
          in_ch.v2_z <= next_tri.c[8];
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= calm || ($urandom_range(99) >= 34);
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t mismatch %s: expected %0d actual %0d", $realtime, name, want, got);
    end
  endtask

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    triangle_t t;
    raster_t w;
    in_taken <= in_ch.valid && in_ch.ready;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        t.idx = in_ch.tri_index;
        t.c[0] = in_ch.v0_x; t.c[1] = in_ch.v0_y; t.c[2] = in_ch.v0_z;
        t.c[3] = in_ch.v1_x; t.c[4] = in_ch.v1_y; t.c[5] = in_ch.v1_z;
        t.c[6] = in_ch.v2_x; t.c[7] = in_ch.v2_y; t.c[8] = in_ch.v2_z;
        raster_q = {raster_q, project_triangle(t)};
      end
      if (out_ch.valid && out_ch.ready) begin
        if (raster_q.size() == 0) begin
          errors++;
          $display("%0t mismatch: unexpected result, index %0d", $realtime, out_ch.out_index);
        end else begin
          w = raster_q.pop_front();
          check_field("out_index", w.idx, out_ch.out_index);
          check_field("visible", w.vis, out_ch.visible);
          check_field("screen_x0", w.sx[0], out_ch.screen_x0);
          check_field("screen_y0", w.sy[0], out_ch.screen_y0);
          check_field("screen_x1", w.sx[1], out_ch.screen_x1);
          check_field("screen_y1", w.sy[1], out_ch.screen_y1);
          check_field("screen_x2", w.sx[2], out_ch.screen_x2);
          check_field("screen_y2", w.sy[2], out_ch.screen_y2);
          check_field("intensity", w.level, out_ch.intensity);
          check_field("depth_key", w.depth, out_ch.depth_key);
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** triangle_geometry_stage: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int persp;
    for (int k = 0; k < 4; k++) begin
      view_m[k] = 64'h1000 << (16 * k);
      proj_m[k] = 64'h1000 << (16 * k);
    end
    in_ch.valid = 1'b0;
    in_ch.tri_index = '0;
    {in_ch.v0_x, in_ch.v0_y, in_ch.v0_z} = '0;
    {in_ch.v1_x, in_ch.v1_y, in_ch.v1_z} = '0;
    {in_ch.v2_x, in_ch.v2_y, in_ch.v2_z} = '0;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // identity, directed triangles
    load_matrices(IDENT_ROW0, IDENT_ROW1, IDENT_ROW2, IDENT_ROW3,
                  IDENT_ROW0, IDENT_ROW1, IDENT_ROW2, IDENT_ROW3);
    push_tri(16'h0000, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    push_tri(16'hFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
             32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    push_tri(16'h8000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
             32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    push_tri(16'h0001, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 32'h7FFFFFFF,
             0, 32'h7FFFFFFF, 32'h7FFFFFFF);
    // front and back facing versions of one triangle
    push_tri(2, 0, 0, 4 << 16, 0, 1 << 16, 4 << 16, 1 << 16, 0, 4 << 16);
    push_tri(3, 0, 0, 4 << 16, 1 << 16, 0, 4 << 16, 0, 1 << 16, 4 << 16);
    // z exactly one, just above
    push_tri(4, 0, 0, 1 << 16, 0, 1 << 16, 1 << 16, 1 << 16, 0, 1 << 16);
    push_tri(5, 0, 0, 65537, 0, 1 << 16, 65537, 1 << 16, 0, 65537);
    // degenerate: collinear vertices
    push_tri(6, 0, 0, 2 << 16, 1 << 16, 1 << 16, 3 << 16, 2 << 16, 2 << 16, 4 << 16);
    // outside in x, outside in y, on the x edge
    push_tri(7, 100 << 16, 0, 4 << 16, 100 << 16, 1 << 16, 4 << 16, 101 << 16, 0, 4 << 16);
    push_tri(8, 0, 100 << 16, 4 << 16, 0, 101 << 16, 4 << 16, 1 << 16, 100 << 16, 4 << 16);
    push_tri(9, 5 << 16, 0, 4 << 16, 5 << 16, 1 << 16, 4 << 16, 6 << 16, 0, 4 << 16);
    push_tri(10, -(3 << 16), -(3 << 16), 3 << 16, 3 << 16, -(3 << 16), 3 << 16,
             0, 3 << 16, 3 << 16);
    push_tri(11, 0, -(3 << 16), 3 << 16, 3 << 16, -(3 << 16), 3 << 16,
             -(3 << 16), -(3 << 16), 3 << 16);
    push_random(150);
    wait_drained();

    // perspective projection with w equal to view z, large stretch with no stalls
    calm = 1'b1;
    load_matrices({near(0, 200), near(0, 200), near(0, 200), near(4096, 400)},
                  {near(0, 200), near(0, 200), near(4096, 400), near(0, 200)},
                  {near(0, 200), near(4096, 400), near(0, 200), near(0, 200)},
                  IDENT_ROW3,
                  {16'h0, 16'h0, 16'h0, near(4096, 800)},
                  {16'h0, 16'h0, near(4096, 800), 16'h0},
                  IDENT_ROW2, IDENT_ROW2);
    push_random(200);
    wait_drained();
    calm = 1'b0;

    // extremes of the matrix entries
    load_matrices({4{16'hFFFF}}, {4{16'hFFFF}}, {4{16'hFFFF}}, {4{16'hFFFF}},
                  {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
    push_random(60);
    wait_drained();
    load_matrices({4{16'h7FFF}}, {4{16'h8000}}, {4{16'h7FFF}}, {4{16'h8000}},
                  {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
    push_random(60);
    wait_drained();
    load_matrices(64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0);
    push_random(30);
    wait_drained();

    // projected w zero: one is used as the divisor in its place
    load_matrices(IDENT_ROW0, IDENT_ROW1, IDENT_ROW2, IDENT_ROW3,
                  IDENT_ROW0, IDENT_ROW1, IDENT_ROW2, 64'h0);
    push_random(120);
    wait_drained();

    // fully random matrices, then perturbed identities and scaled perspectives
    load_matrices(rand64(), rand64(), rand64(), rand64(),
                  rand64(), rand64(), rand64(), rand64());
    push_random(60);
    wait_drained();
    for (int ph = 0; ph < 4; ph++) begin
      persp = $urandom_range(1);
      load_matrices({near(0, 100), near(0, 100), near(0, 100), near(4096, 300)},
                    {near(0, 100), near(0, 100), near(4096, 300), near(0, 100)},
                    {near(0, 100), near(4096, 300), near(0, 100), near(0, 100)},
                    {near(4096, 50), near(0, 50), near(0, 50), near(0, 50)},
                    {near(0, 50), near(0, 50), near(0, 50), near(4096, 4000)},
                    {near(0, 50), near(0, 50), near(4096, 4000), near(0, 50)},
                    IDENT_ROW2,
                    persp ? {16'h0, near(4096, 1000), 16'h0, 16'h0} : IDENT_ROW3);
      push_random(130);
      wait_drained();
    end

    if (errors == 0) begin
      $display("** triangle_geometry_stage: PASSED **");
    end else begin
      $display("** triangle_geometry_stage: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/tgs_pkg.sv
src/tgs_channels.sv
src/tgs_div.sv
src/tgs_sqrt.sv
src/triangle_geometry_stage.sv
bench/triangle_geometry_stage_tb.sv
